>>> rtl/aip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aip_pkg
// Shared widths, character codes and character classification helpers for
// the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int VALUE_BITS  = 64;
    localparam int CHAR_BITS   = 8;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 7;
    localparam int RESULT_BITS = 64;

    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UC_X  = 8'h58;
    localparam logic [CHAR_BITS-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LC_X  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CHAR_LC_Z  = 8'h7A;

    localparam logic [RADIX_BITS-1:0] BASE_AUTO = 6'd0;
    localparam logic [RADIX_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [RADIX_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [RADIX_BITS-1:0] BASE_HEX  = 6'd16;

    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE   = 7'd64;
    localparam logic [DIGIT_BITS-1:0] DIGIT_LETTER = 7'd10;

    // Space, tab, LF, VT, FF, CR.
    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Digit value 0..35, or DIGIT_NONE for a non-alphanumeric character.
    function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [DIGIT_BITS-1:0] d;
        d = DIGIT_NONE;
        if ((c >= CHAR_ZERO) && (c <= CHAR_NINE))
        begin
            d = DIGIT_BITS'(c - CHAR_ZERO);
        end
        else if ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z))
        begin
            d = DIGIT_BITS'(c - CHAR_LC_A) + DIGIT_LETTER;
        end
        else if ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z))
        begin
            d = DIGIT_BITS'(c - CHAR_UC_A) + DIGIT_LETTER;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

>>> rtl/aip_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aip_char_if / aip_result_if
// Valid/ready channels for the character stream and the parse results.
// ----------------------------------------------------------------------------
interface aip_char_if;
    logic                              valid;
    logic                              ready;
    logic [aip_pkg::CHAR_BITS-1:0]     ch;
    logic                              start_req;
    logic [aip_pkg::RADIX_BITS-1:0]    radix;

    modport source (output valid, output ch, output start_req, output radix, input ready);
    modport sink   (input valid, input ch, input start_req, input radix, output ready);
endinterface

interface aip_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [aip_pkg::RESULT_BITS-1:0] value;
    logic [aip_pkg::OFFSET_BITS-1:0]        end_offset;

    modport source (output valid, output value, output end_offset, input ready);
    modport sink   (input valid, input value, input end_offset, output ready);
endinterface
`default_nettype wire

>>> rtl/ascii_integer_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Streaming string-to-integer converter: whitespace skip, optional sign,
// radix prefix detection and digit accumulation, one character per transfer.
// ----------------------------------------------------------------------------
// Datapath: a character transfer fills the input register, then one pass of
//   parse logic carries it into the result register.
// Throughput: 1 character per cycle, set by the combinational multiply-add of
//   the accumulator by the 6-bit base; stalls only while a result waits.
// Reset: asynchronous; parser stopped, waiting for a start character, both
//   register stages empty.
module ascii_integer_parser_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    aip_char_if.sink           chars,
    aip_result_if.source       results
);

    typedef enum logic [2:0] {
        PH_STOPPED,
        PH_SKIP,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    localparam logic [aip_pkg::OFFSET_BITS-1:0] OFF_MAX = '1;

    // input register
    logic                               in_valid_reg;
    logic [aip_pkg::CHAR_BITS-1:0]      ch_reg;
    logic                               start_reg;
    logic [aip_pkg::RADIX_BITS-1:0]     radix_reg;

    // parser state
    phase_t                             phase_reg, phase_next;
    logic                               negative_reg, negative_next;
    logic [aip_pkg::RADIX_BITS-1:0]     base_reg, base_next;
    logic [aip_pkg::VALUE_BITS-1:0]     accum_reg, accum_next;
    logic [aip_pkg::OFFSET_BITS-1:0]    count_reg, count_next;

    // result register
    logic                               out_valid_reg;
    logic signed [aip_pkg::RESULT_BITS-1:0] value_reg, value_next;
    logic [aip_pkg::OFFSET_BITS-1:0]    offset_reg;

    logic                               advance;
    logic                               emit;
    logic [aip_pkg::DIGIT_BITS-1:0]     digit;
    logic [aip_pkg::VALUE_BITS+aip_pkg::RADIX_BITS-1:0] product;
    logic [aip_pkg::VALUE_BITS-1:0]     mag;
    logic signed [aip_pkg::VALUE_BITS-1:0] mag_signed;

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready   = !in_valid_reg || advance;
    assign digit         = aip_pkg::digit_of(ch_reg);

    assign results.valid      = out_valid_reg;
    assign results.value      = value_reg;
    assign results.end_offset = offset_reg;

    always_comb
    begin
        logic handled;
        logic [aip_pkg::RADIX_BITS-1:0] base_v;
        phase_next    = phase_reg;
        negative_next = negative_reg;
        base_next     = base_reg;
        accum_next    = accum_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        handled       = 1'b0;
        base_v        = '0;
        product       = '0;

        if (start_reg)
        begin
            phase_next    = PH_SKIP;
            negative_next = 1'b0;
            base_next     = radix_reg;
            accum_next    = '0;
            count_next    = '0;
        end

        if (phase_next != PH_STOPPED)
        begin
            if (phase_next == PH_SKIP)
            begin
                if (aip_pkg::is_space(ch_reg))
                begin
                    handled = 1'b1;
                end
                else if ((ch_reg == aip_pkg::CHAR_MINUS) || (ch_reg == aip_pkg::CHAR_PLUS))
                begin
                    negative_next = (ch_reg == aip_pkg::CHAR_MINUS);
                    phase_next    = PH_PREFIX;
                    handled       = 1'b1;
                end
                else
                begin
                    phase_next = PH_PREFIX;
                end
            end

            if (!handled && (phase_next == PH_PREFIX))
            begin
                if (((base_next == aip_pkg::BASE_AUTO) || (base_next == aip_pkg::BASE_HEX))
                    && (ch_reg == aip_pkg::CHAR_ZERO))
                begin
                    phase_next = PH_ZERO;
                    handled    = 1'b1;
                end
                else
                begin
                    if (base_next == aip_pkg::BASE_AUTO)
                    begin
                        base_next = aip_pkg::BASE_DEC;
                    end
                    phase_next = PH_DIGITS;
                end
            end

            if (!handled && (phase_next == PH_ZERO))
            begin
                if ((ch_reg == aip_pkg::CHAR_LC_X) || (ch_reg == aip_pkg::CHAR_UC_X))
                begin
                    base_next  = aip_pkg::BASE_HEX;
                    phase_next = PH_DIGITS;
                    handled    = 1'b1;
                end
                else
                begin
                    if (base_next == aip_pkg::BASE_AUTO)
                    begin
                        base_next = aip_pkg::BASE_OCT;
                    end
                    phase_next = PH_DIGITS;
                end
            end

            // every path that is not yet handled has reached the digit phase
            if (!handled)
            begin
                base_v = base_next;
                if ((ch_reg == aip_pkg::CHAR_NUL) || (digit >= {1'b0, base_v}))
                begin
                    emit       = 1'b1;
                    phase_next = PH_STOPPED;
                end
                else
                begin
                    product    = accum_next * base_v;
                    accum_next = product[aip_pkg::VALUE_BITS-1:0]
                                 + aip_pkg::VALUE_BITS'(digit);
                    handled    = 1'b1;
                end
            end

            // count every handled character, saturating; the terminator is not counted
            if (handled && (count_next != OFF_MAX))
            begin
                count_next = count_next + aip_pkg::OFFSET_BITS'(1);
            end
        end
    end

    assign mag        = negative_next ? (aip_pkg::VALUE_BITS'(0) - accum_next) : accum_next;
    assign mag_signed = mag;
    assign value_next = aip_pkg::RESULT_BITS'(mag_signed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_STOPPED;
            negative_reg  <= 1'b0;
            base_reg      <= '0;
            accum_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            // hold the input register until the parse step can advance
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end

            if (advance)
            begin
                phase_reg    <= phase_next;
                negative_reg <= negative_next;
                base_reg     <= base_next;
                accum_reg    <= accum_next;
                count_reg    <= count_next;
                out_valid_reg <= emit;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg    <= chars.ch;
            start_reg <= chars.start_req;
            radix_reg <= chars.radix;
        end
        if (advance && emit)
        begin
            value_reg  <= value_next;
            offset_reg <= count_next;
        end
    end

endmodule
`default_nettype wire
